// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds on every clock edge out of reset
`define SAW_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle
`define SAW_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a trigger implies a consequence in the next cycle
`define SAW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/saw_pkg.sv =====
// Types, widths and codes of the stop-and-wait ARQ sender
package saw_pkg;

   localparam int OPCODE_W  = 3;
   localparam int BYTE_W    = 8;
   localparam int STATUS_W  = 3;
   localparam int LENGTH_W  = 10;
   localparam int ATTEMPT_W = 4;
   localparam int TICK_W    = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;

   // Longest frame kept; further bytes are dropped
   localparam int MAX_PAYLOAD = 1023;
   localparam int CAP_INT = (MAX_PAYLOAD < 1023) ? MAX_PAYLOAD : 1023;
   localparam logic [LENGTH_W-1:0] PAYLOAD_CAP = LENGTH_W'(CAP_INT);

   // Register reset values
   localparam logic [ATTEMPT_W-1:0] RETRY_LIMIT_RST   = 4'd5;
   localparam logic [TICK_W-1:0]    TIMEOUT_TICKS_RST = 16'd3000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_LIMIT   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS = 1'd1;

   // Request opcodes
   localparam logic [OPCODE_W-1:0] OP_PAYLOAD   = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_END_FRAME = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_ACK       = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_TICK      = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_LINK_DOWN = 3'd4;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_NOTHING   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_SENT      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RESENT    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ACKED     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd4;
   localparam logic [STATUS_W-1:0] ST_LINKFAIL  = 3'd5;
   localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd6;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic                 frame_seq;
      logic [BYTE_W-1:0]    frame_checksum;
      logic [LENGTH_W-1:0]  frame_length;
      logic [ATTEMPT_W-1:0] attempt;
      logic                 busy_res;
   } rsp_type;

endpackage

// ===== rtl/core/saw_channels.sv =====
// Request and response channel interfaces of the ARQ sender
interface saw_req_if;
   logic                            valid;
   logic                            ready;
   logic [saw_pkg::OPCODE_W-1:0]    opcode;
   logic [saw_pkg::BYTE_W-1:0]      payload_byte;
   logic                            last_byte;
   logic [saw_pkg::BYTE_W-1:0]      ack_number;
   logic [saw_pkg::BYTE_W-1:0]      ack_check;

   modport source (output valid, opcode, payload_byte, last_byte, ack_number, ack_check,
                   input ready);
   modport sink   (input valid, opcode, payload_byte, last_byte, ack_number, ack_check,
                   output ready);
endinterface

interface saw_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [saw_pkg::STATUS_W-1:0]    status;
   logic                            frame_seq;
   logic [saw_pkg::BYTE_W-1:0]      frame_checksum;
   logic [saw_pkg::LENGTH_W-1:0]    frame_length;
   logic [saw_pkg::ATTEMPT_W-1:0]   attempt;
   logic                            busy_res;

   modport source (output valid, status, frame_seq, frame_checksum, frame_length, attempt,
                   busy_res, input ready);
   modport sink   (input valid, status, frame_seq, frame_checksum, frame_length, attempt,
                   busy_res, output ready);
endinterface

// ===== rtl/core/stop_and_wait_arq_sender.sv =====
// Stop-and-wait ARQ sender: frame accounting, retry control and response register
//
//   channel   direction  handshake           carries
//   req_chan  in         valid/ready         opcode, byte, last mark, ACK fields
//   rsp_chan  out        valid/ready         status and frame report, one per request
//   csr_*     in         write enable only   retry limit, timeout in ticks
//
// Each request is processed in the cycle it is accepted; its response is
// registered and appears in the next cycle. A request is taken every cycle
// while the response register is empty or being emptied in the same cycle.
// Stalls on the response side hold the response and block new requests.
// Synchronous reset clears frame state and response valid, presets the CSRs.
`include "assert_macros.svh"

module stop_and_wait_arq_sender (
   input  logic                           clock,
   input  logic                           reset,
   saw_req_if.sink                        req_chan,
   saw_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [saw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [saw_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import saw_pkg::*;

   logic [ATTEMPT_W-1:0] retry_limit_ff;
   logic [TICK_W-1:0]    timeout_ff;

   logic                 seq_ff,      seq_in;
   logic                 waiting_ff,  waiting_in;
   logic [BYTE_W-1:0]    sum_ff,      sum_in;
   logic [LENGTH_W-1:0]  count_ff,    count_in;
   logic [ATTEMPT_W-1:0] attempts_ff, attempts_in;
   logic [TICK_W-1:0]    tick_ff,     tick_in;

   logic                 rsp_valid_ff;
   rsp_type              rsp_ff, rsp_in;

   logic                 accept;
   logic                 ack_good;
   logic [TICK_W:0]      tick_next;
   logic                 out_of_retries;

   // Accept while the response slot is free or draining
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign ack_good  = (req_chan.ack_number == req_chan.ack_check) &&
                      (req_chan.ack_number == {{(BYTE_W-1){1'b0}}, seq_ff});
   assign tick_next = {1'b0, tick_ff} + {{TICK_W{1'b0}}, 1'b1};
   assign out_of_retries = attempts_ff >= retry_limit_ff;

   // Work out the next frame state and the response
   always_comb begin
      seq_in      = seq_ff;
      waiting_in  = waiting_ff;
      sum_in      = sum_ff;
      count_in    = count_ff;
      attempts_in = attempts_ff;
      tick_in     = tick_ff;
      rsp_in      = '{status: ST_IGNORED, frame_seq: seq_ff, frame_checksum: sum_ff,
                      frame_length: count_ff, attempt: attempts_ff, busy_res: waiting_ff};

      priority if (req_chan.opcode == OP_LINK_DOWN) begin
         rsp_in.status   = ST_LINKFAIL;
         rsp_in.busy_res = 1'b0;
         waiting_in  = 1'b0;
         sum_in      = '0;
         count_in    = '0;
         attempts_in = '0;
         tick_in     = '0;
      end else if (!waiting_ff) begin
         unique case (req_chan.opcode)
            OP_PAYLOAD: begin
               // Drop bytes beyond the cap, still honour the last mark
               if (count_ff < PAYLOAD_CAP) begin
                  sum_in   = sum_ff + req_chan.payload_byte;
                  count_in = count_ff + LENGTH_W'(1);
               end
               rsp_in.frame_checksum = sum_in;
               rsp_in.frame_length   = count_in;
               if (req_chan.last_byte) begin
                  waiting_in      = 1'b1;
                  attempts_in     = ATTEMPT_W'(1);
                  tick_in         = '0;
                  rsp_in.status   = ST_SENT;
                  rsp_in.attempt  = ATTEMPT_W'(1);
                  rsp_in.busy_res = 1'b1;
               end else begin
                  rsp_in.status = ST_NOTHING;
               end
            end
            OP_END_FRAME: begin
               if (count_ff == '0) begin
                  waiting_in      = 1'b1;
                  attempts_in     = ATTEMPT_W'(1);
                  tick_in         = '0;
                  rsp_in.status   = ST_SENT;
                  rsp_in.attempt  = ATTEMPT_W'(1);
                  rsp_in.busy_res = 1'b1;
               end
            end
            OP_TICK: rsp_in.status = ST_NOTHING;
            default: rsp_in.status = ST_IGNORED;
         endcase
      end else begin
         unique case (req_chan.opcode)
            OP_ACK, OP_TICK: begin
               if (req_chan.opcode == OP_ACK && ack_good) begin
                  // Frame delivered: report it, flip the sequence bit
                  rsp_in.status   = ST_ACKED;
                  rsp_in.busy_res = 1'b0;
                  seq_in      = !seq_ff;
                  waiting_in  = 1'b0;
                  sum_in      = '0;
                  count_in    = '0;
                  attempts_in = '0;
                  tick_in     = '0;
               end else if (req_chan.opcode == OP_TICK &&
                            tick_next < {1'b0, timeout_ff}) begin
                  tick_in       = tick_next[TICK_W-1:0];
                  rsp_in.status = ST_NOTHING;
               end else if (out_of_retries) begin
                  // Bad ACK or timeout with no attempts left
                  rsp_in.status   = ST_EXHAUSTED;
                  rsp_in.busy_res = 1'b0;
                  waiting_in  = 1'b0;
                  sum_in      = '0;
                  count_in    = '0;
                  attempts_in = '0;
                  tick_in     = '0;
               end else begin
                  attempts_in    = attempts_ff + ATTEMPT_W'(1);
                  tick_in        = '0;
                  rsp_in.status  = ST_RESENT;
                  rsp_in.attempt = attempts_in;
               end
            end
            default: rsp_in.status = ST_IGNORED;
         endcase
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= RETRY_LIMIT_RST;
         timeout_ff     <= TIMEOUT_TICKS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RETRY_LIMIT:   retry_limit_ff <= csr_wdata[ATTEMPT_W-1:0];
            CSR_TIMEOUT_TICKS: timeout_ff     <= csr_wdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   // Frame state: advance on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff      <= 1'b0;
         waiting_ff  <= 1'b0;
         sum_ff      <= '0;
         count_ff    <= '0;
         attempts_ff <= '0;
         tick_ff     <= '0;
      end else if (accept) begin
         seq_ff      <= seq_in;
         waiting_ff  <= waiting_in;
         sum_ff      <= sum_in;
         count_ff    <= count_in;
         attempts_ff <= attempts_in;
         tick_ff     <= tick_in;
      end
   end

   // Response register: load on accept, hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_ff.status;
   assign rsp_chan.frame_seq      = rsp_ff.frame_seq;
   assign rsp_chan.frame_checksum = rsp_ff.frame_checksum;
   assign rsp_chan.frame_length   = rsp_ff.frame_length;
   assign rsp_chan.attempt        = rsp_ff.attempt;
   assign rsp_chan.busy_res       = rsp_ff.busy_res;

   `SAW_ASSERT_IMPL(a_wait_has_attempt, clock, reset, waiting_ff, attempts_ff != '0, "waiting with no attempt counted")
   `SAW_ASSERT_IMPL(a_idle_counters_clear, clock, reset, !waiting_ff, attempts_ff == '0 && tick_ff == '0, "idle with attempt or tick count left")
   `SAW_ASSERT(a_length_capped, clock, reset, count_ff <= PAYLOAD_CAP, "frame length above cap")
   `SAW_ASSERT_NEXT(a_ack_flips_seq, clock, reset, accept && rsp_in.status == ST_ACKED, seq_ff != $past(seq_ff) && !waiting_ff, "acknowledge did not flip sequence bit")

endmodule

// ===== tb/stop_and_wait_arq_sender_tb.sv =====
// Self-checking testbench of the stop-and-wait ARQ sender: random frames and ACK traffic
module stop_and_wait_arq_sender_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import saw_pkg::*;

   // Opcodes outside the defined set
   localparam logic [OPCODE_W-1:0] OP_SPARE_5 = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

   // Frame accounting predictor and store of expected responses
   class arq_scoreboard;
      rsp_type              expected_q[$];
      int unsigned          errors;
      int unsigned          checked;
      logic [ATTEMPT_W-1:0] retry_limit;
      logic [TICK_W-1:0]    timeout_ticks;
      logic                 sequence_bit;
      logic                 waiting_ack;
      logic [BYTE_W-1:0]    checksum;
      logic [LENGTH_W-1:0]  byte_count;
      logic [ATTEMPT_W-1:0] attempts;
      logic [TICK_W-1:0]    tick_count;

      function new();
         errors        = 0;
         checked       = 0;
         retry_limit   = RETRY_LIMIT_RST;
         timeout_ticks = TIMEOUT_TICKS_RST;
         sequence_bit  = 1'b0;
         clear_frame();
      endfunction

      function void clear_frame();
         waiting_ack = 1'b0;
         checksum    = '0;
         byte_count  = '0;
         attempts    = '0;
         tick_count  = '0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] data);
         if (index == CSR_RETRY_LIMIT)
            retry_limit = data[ATTEMPT_W-1:0];
         else if (index == CSR_TIMEOUT_TICKS)
            timeout_ticks = data[TICK_W-1:0];
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function rsp_type frame_report(logic [STATUS_W-1:0] status,
                                     logic [ATTEMPT_W-1:0] att, logic busy);
         rsp_type r;
         r.status         = status;
         r.frame_seq      = sequence_bit;
         r.frame_checksum = checksum;
         r.frame_length   = byte_count;
         r.attempt        = att;
         r.busy_res       = busy;
         return r;
      endfunction

      function rsp_type start_send();
         waiting_ack = 1'b1;
         attempts    = 4'd1;
         tick_count  = '0;
         return frame_report(ST_SENT, 4'd1, 1'b1);
      endfunction

      // Resend, or drop the frame once the attempts are used up
      function rsp_type retry_or_give_up();
         rsp_type r;
         if (attempts >= retry_limit) begin
            r = frame_report(ST_EXHAUSTED, attempts, 1'b0);
            clear_frame();
         end else begin
            attempts   = attempts + 1'b1;
            tick_count = '0;
            r = frame_report(ST_RESENT, attempts, 1'b1);
         end
         return r;
      endfunction

      // Advance the predicted state by one accepted request; return its status
      function logic [STATUS_W-1:0] note_request(logic [OPCODE_W-1:0] op,
                                                 logic [BYTE_W-1:0] data, logic is_last,
                                                 logic [BYTE_W-1:0] ack_num,
                                                 logic [BYTE_W-1:0] ack_chk);
         rsp_type r;
         if (op == OP_LINK_DOWN) begin
            r = frame_report(ST_LINKFAIL, attempts, 1'b0);
            clear_frame();
         end else if (!waiting_ack) begin
            if (op == OP_PAYLOAD) begin
               if (byte_count < PAYLOAD_CAP) begin
                  checksum   = checksum + data;
                  byte_count = byte_count + 1'b1;
               end
               r = is_last ? start_send() : frame_report(ST_NOTHING, '0, 1'b0);
            end else if (op == OP_END_FRAME) begin
               r = (byte_count == '0) ? start_send() : frame_report(ST_IGNORED, '0, 1'b0);
            end else if (op == OP_TICK) begin
               r = frame_report(ST_NOTHING, '0, 1'b0);
            end else begin
               r = frame_report(ST_IGNORED, '0, 1'b0);
            end
         end else if (op == OP_ACK) begin
            if (ack_num != ack_chk || ack_num != {7'b0, sequence_bit}) begin
               r = retry_or_give_up();
            end else begin
               r = frame_report(ST_ACKED, attempts, 1'b0);
               sequence_bit = ~sequence_bit;
               clear_frame();
            end
         end else if (op == OP_TICK) begin
            tick_count = tick_count + 1'b1;
            if (tick_count >= timeout_ticks)
               r = retry_or_give_up();
            else
               r = frame_report(ST_NOTHING, attempts, 1'b1);
         end else begin
            r = frame_report(ST_IGNORED, attempts, 1'b1);
         end
         expected_q.push_back(r);
         return r.status;
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= 40)
            $display("%0t mismatch: %s", $realtime, msg);
      endtask

      // Compare one response with the oldest expectation
      task check_response(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            report_mismatch("response with no request outstanding");
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (got.status !== want.status)
            report_mismatch($sformatf("rsp %0d status %0d, want %0d",
                                      checked, got.status, want.status));
         if (got.frame_seq !== want.frame_seq)
            report_mismatch($sformatf("rsp %0d frame_seq %0b, want %0b",
                                      checked, got.frame_seq, want.frame_seq));
         if (got.frame_checksum !== want.frame_checksum)
            report_mismatch($sformatf("rsp %0d frame_checksum %0h, want %0h",
                                      checked, got.frame_checksum, want.frame_checksum));
         if (got.frame_length !== want.frame_length)
            report_mismatch($sformatf("rsp %0d frame_length %0d, want %0d",
                                      checked, got.frame_length, want.frame_length));
         if (got.attempt !== want.attempt)
            report_mismatch($sformatf("rsp %0d attempt %0d, want %0d",
                                      checked, got.attempt, want.attempt));
         if (got.busy_res !== want.busy_res)
            report_mismatch($sformatf("rsp %0d busy_res %0b, want %0b",
                                      checked, got.busy_res, want.busy_res));
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   saw_req_if req_if ();
   saw_rsp_if rsp_if ();

   arq_scoreboard sb;
   bit            gapless;
   bit            hold_off_req;
   int unsigned   items_done;

   stop_and_wait_arq_sender DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if.sink),
      .rsp_chan  (rsp_if.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Mostly no gap, sometimes a short one, rarely a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   function automatic logic [BYTE_W-1:0] seq_ack();
      return {7'b0, sb.sequence_bit};
   endfunction

   // Offer one transaction, hold it until taken, then note it
   task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [BYTE_W-1:0] data,
                               input logic is_last, input logic [BYTE_W-1:0] ack_num,
                               input logic [BYTE_W-1:0] ack_chk);
      int gap;
      gap = gapless ? 0 : pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.opcode       <= op;
      req_if.payload_byte <= data;
      req_if.last_byte    <= is_last;
      req_if.ack_number   <= ack_num;
      req_if.ack_check    <= ack_chk;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      if (sb.note_request(op, data, is_last, ack_num, ack_chk) != ST_IGNORED)
         items_done++;
   endtask

   // Drain outstanding responses, then write both registers
   task automatic configure(input logic [CSR_DATA_W-1:0] retry_data,
                            input logic [CSR_DATA_W-1:0] timeout_data);
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_RETRY_LIMIT;
      csr_wdata <= retry_data;
      @(posedge clock);
      sb.write_register(CSR_RETRY_LIMIT, retry_data);
      csr_index <= CSR_TIMEOUT_TICKS;
      csr_wdata <= timeout_data;
      @(posedge clock);
      sb.write_register(CSR_TIMEOUT_TICKS, timeout_data);
      csr_we <= 1'b0;
   endtask

   task automatic send_noise();
      send_request(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), 8'($urandom),
                   8'($urandom));
   endtask

   // Stream a payload frame; a link drop may cut it short
   task automatic send_frame(input int len);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 59) == 0) begin
            send_request(OP_LINK_DOWN, 8'($urandom), 1'($urandom), 8'($urandom),
                         8'($urandom));
            return;
         end
         send_request(OP_PAYLOAD, 8'($urandom), i == len - 1, 8'($urandom), 8'($urandom));
      end
   endtask

   // Answer the frame in flight with ACKs, bad ACKs, ticks and stray requests
   task automatic answer_frame();
      int                  r;
      logic [BYTE_W-1:0]   n;
      logic [OPCODE_W-1:0] stray_op;
      while (sb.waiting_ack) begin
         r = $urandom_range(0, 99);
         if (r < 30) begin
            send_request(OP_ACK, 8'($urandom), 1'($urandom), seq_ack(), seq_ack());
         end else if (r < 38) begin
            n = ($urandom_range(0, 3) == 0) ? 8'($urandom) : seq_ack();
            send_request(OP_ACK, 8'($urandom), 1'($urandom), n,
                         n ^ 8'($urandom_range(1, 255)));
         end else if (r < 46) begin
            n = 8'($urandom);
            if (n == seq_ack())
               n = n ^ 8'h80;
            send_request(OP_ACK, 8'($urandom), 1'($urandom), n, n);
         end else if (r < 88) begin
            send_request(OP_TICK, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
         end else if (r < 96) begin
            case ($urandom_range(0, 4))
               0: stray_op = OP_PAYLOAD;
               1: stray_op = OP_END_FRAME;
               2: stray_op = OP_SPARE_5;
               3: stray_op = OP_SPARE_6;
               default: stray_op = OP_SPARE_7;
            endcase
            send_request(stray_op, 8'($urandom), 1'($urandom), 8'($urandom),
                         8'($urandom));
         end else begin
            send_request(OP_LINK_DOWN, 8'($urandom), 1'($urandom), 8'($urandom),
                         8'($urandom));
         end
      end
   endtask

   // Mostly well-formed frames with their answers, some noise in between
   task automatic run_traffic(input int target);
      int stop_at;
      stop_at = items_done + target;
      while (items_done < stop_at) begin
         gapless = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 15) == 0)
            send_noise();
         else if ($urandom_range(0, 5) == 0)
            send_request(OP_END_FRAME, 8'($urandom), 1'($urandom), 8'($urandom),
                         8'($urandom));
         else if ($urandom_range(0, 7) == 0)
            send_frame($urandom_range(13, 60));
         else
            send_frame($urandom_range(1, 12));
         answer_frame();
      end
      gapless = 1'b0;
   endtask

   // Walk through each opcode and corner case once
   task automatic run_directed();
      send_request(OP_PAYLOAD, 8'hFF, 1'b0, 8'h00, 8'hFF);
      send_request(OP_PAYLOAD, 8'h00, 1'b0, 8'hFF, 8'h00);
      // end frame with bytes pending, ACK and tick while idle
      send_request(OP_END_FRAME, 8'h00, 1'b0, 8'h00, 8'h00);
      send_request(OP_ACK, 8'h00, 1'b0, seq_ack(), seq_ack());
      send_request(OP_TICK, 8'h00, 1'b0, 8'h00, 8'h00);
      send_request(OP_SPARE_5, 8'hFF, 1'b1, 8'hFF, 8'hFF);
      send_request(OP_SPARE_6, 8'h00, 1'b0, 8'h00, 8'h00);
      send_request(OP_SPARE_7, 8'hAA, 1'b1, 8'h55, 8'hAA);
      send_request(OP_PAYLOAD, 8'h80, 1'b1, 8'h00, 8'h00);
      // stray requests while waiting
      send_request(OP_PAYLOAD, 8'h01, 1'b1, 8'h00, 8'h00);
      send_request(OP_END_FRAME, 8'h00, 1'b0, 8'h00, 8'h00);
      send_request(OP_SPARE_7, 8'h00, 1'b0, 8'h00, 8'h00);
      // bad check field, then timeout until the attempts run out
      send_request(OP_ACK, 8'h00, 1'b0, seq_ack(), seq_ack() ^ 8'hFF);
      send_request(OP_TICK, 8'h00, 1'b0, 8'h00, 8'h00);
      send_request(OP_TICK, 8'h00, 1'b0, 8'h00, 8'h00);
      // link drop on a partial frame
      send_request(OP_PAYLOAD, 8'h11, 1'b0, 8'h00, 8'h00);
      send_request(OP_LINK_DOWN, 8'h00, 1'b0, 8'h00, 8'h00);
      // empty frame, wide ACK number, then wrong number
      send_request(OP_END_FRAME, 8'h00, 1'b0, 8'h00, 8'h00);
      send_request(OP_ACK, 8'h00, 1'b0, 8'hFF, 8'hFF);
      send_request(OP_ACK, 8'h00, 1'b0, seq_ack() ^ 8'h01, seq_ack() ^ 8'h01);
      // clean acknowledgment toggles the sequence bit
      send_request(OP_END_FRAME, 8'h00, 1'b0, 8'h00, 8'h00);
      send_request(OP_ACK, 8'h00, 1'b0, seq_ack(), seq_ack());
      // link drop while waiting
      send_request(OP_PAYLOAD, 8'h5A, 1'b1, 8'h00, 8'h00);
      send_request(OP_LINK_DOWN, 8'h00, 1'b0, 8'h00, 8'h00);
      send_request(OP_END_FRAME, 8'h00, 1'b0, 8'h00, 8'h00);
      send_request(OP_ACK, 8'h00, 1'b0, seq_ack(), seq_ack());
   endtask

   // Result side: steady stretches, random stalls, and one long hold-off on request
   initial begin : receiver
      int run_left;
      int stall_left;
      int hold_left;
      bit steady;
      run_left   = 0;
      stall_left = 0;
      hold_left  = 0;
      steady     = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         if (hold_off_req) begin
            hold_left    = 150;
            hold_off_req = 1'b0;
         end
         if (run_left == 0) begin
            steady   = ($urandom_range(0, 3) == 0);
            run_left = $urandom_range(10, 80);
         end
         run_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (!steady && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            rsp_if.ready <= (stall_left == 0);
            if (stall_left > 0)
               stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   // Check every response taken
   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got.status         = rsp_if.status;
         got.frame_seq      = rsp_if.frame_seq;
         got.frame_checksum = rsp_if.frame_checksum;
         got.frame_length   = rsp_if.frame_length;
         got.attempt        = rsp_if.attempt;
         got.busy_res       = rsp_if.busy_res;
         sb.check_response(got);
      end
   end

   initial begin : stimulus
      int long_len;
      sb           = new();
      gapless      = 1'b0;
      hold_off_req = 1'b0;
      items_done   = 0;
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      req_if.valid        = 1'b0;
      req_if.opcode       = '0;
      req_if.payload_byte = '0;
      req_if.last_byte    = 1'b0;
      req_if.ack_number   = '0;
      req_if.ack_check    = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // register values from reset
      run_traffic(80);

      configure(16'h0002, 16'd2);
      run_directed();

      // extremes of both registers
      configure(16'd0, 16'd0);
      run_traffic(130);
      configure(16'd1, 16'd1);
      run_traffic(130);
      configure(16'hFFFF, 16'hFFFF);
      hold_off_req = 1'b1;
      run_traffic(130);
      configure(16'd15, 16'd1);
      run_traffic(130);

      // overlong frame: bytes past the cap are dropped, the last mark still sends
      configure(16'd3, 16'd4);
      long_len = int'(PAYLOAD_CAP) + $urandom_range(1, 6);
      gapless = 1'b1;
      for (int i = 0; i < long_len; i++)
         send_request(OP_PAYLOAD, 8'($urandom), i == long_len - 1, 8'($urandom),
                      8'($urandom));
      gapless = 1'b0;
      answer_frame();
      run_traffic(80);

      // random settings, upper data bits set at random
      for (int p = 0; p < 3; p++) begin
         configure({12'($urandom), 4'($urandom_range(1, 15))},
                   16'($urandom_range(1, 12)));
         run_traffic(50);
      end

      // drain and let the response register settle
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d responses never arrived", sb.pending()));
      if (sb.errors == 0)
         $display("PASS stop_and_wait_arq_sender");
      else
         $display("FAIL stop_and_wait_arq_sender");
      $finish;
   end

   initial begin : watchdog
      #30_000_000;
      $display("FAIL stop_and_wait_arq_sender");
      $finish;
   end

endmodule
